FILE: rtl/core/bab_pkg.sv
// Shared constants and types for the block allocation bitmap.
// Used by the map RAM, the bit pick unit and the top-level sequencer.
// No dependencies.
package bab_pkg;

    // Map geometry
    localparam int NUM_BLOCKS = 1024;
    localparam int MAP_BYTES  = (NUM_BLOCKS + 7) / 8;
    localparam int ADDR_W     = $clog2(MAP_BYTES);
    localparam int CNT_W      = 11;   // block counts and range limits
    localparam int ID_W       = 10;   // block identifiers
    localparam int WANT_W     = 6;    // wanted and found counts
    localparam int KIND_W     = 3;

    localparam logic [CNT_W-1:0]  NUM_BLOCKS_C  = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]  SIZE_RESET    = CNT_W'(1024);
    localparam logic [WANT_W-1:0] MAX_REPORT    = WANT_W'(63);

    // Operation codes carried in the input tuser
    localparam logic [KIND_W-1:0] KIND_SET   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIST  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND  = 3'd4;

    // Lowest candidate bit of a working byte
    typedef struct packed {
        logic       found;
        logic [2:0] pos;
    } pick_t;

endpackage

FILE: rtl/core/bab_map_ram.sv
// Bitmap store: one byte per row, one write and one registered read per cycle.
// Row valid flags cleared at reset make unwritten rows read as all free.
// Depends on bab_pkg.
module bab_map_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [bab_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data,
    input  logic                       wr_en,
    input  logic [bab_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data
);
    import bab_pkg::*;

    logic [7:0]           mem_reg [MAP_BYTES];
    logic [MAP_BYTES-1:0] row_valid_reg;
    logic [7:0]           rdata_reg;
    logic                 rvalid_reg;

    // Mark rows once written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Write the array, register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    // A row never written reads as all free
    assign rd_data = rvalid_reg ? rdata_reg : 8'h00;

endmodule

FILE: rtl/core/bab_pick_unit.sv
// Shared bit unit: qualifies the bits of one map byte against a block range
// and picks the lowest remaining candidate of the working byte.
// Depends on bab_pkg.
module bab_pick_unit (
    input  logic [bab_pkg::ADDR_W-1:0] addr,
    input  logic [7:0]                 map_byte,
    input  logic [bab_pkg::CNT_W-1:0]  lo,
    input  logic [bab_pkg::CNT_W-1:0]  stop,
    input  logic                       want_free,
    input  logic [7:0]                 work,
    output logic [7:0]                 qual,
    output bab_pkg::pick_t             pick
);
    import bab_pkg::*;

    // Keep bits inside [lo, stop) that match the wanted flag
    always_comb
    begin
        logic [CNT_W-1:0] id;
        for (int j = 0; j < 8; j++)
        begin
            id      = CNT_W'({addr, 3'(j)});
            qual[j] = (id >= lo) && (id < stop) && (want_free ? !map_byte[j] : map_byte[j]);
        end
    end

    // Lowest set bit of the working byte
    always_comb
    begin
        pick.found = |work;
        pick.pos   = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (work[j])
            begin
                pick.pos = 3'(j);
            end
        end
    end

endmodule

FILE: rtl/core/block_allocation_bitmap.sv
// Block allocation bitmap: top level with the operation sequencer.
// Depends on bab_pkg, bab_map_ram and bab_pick_unit.
//
// Usage: one item enters on the s_axis channel (tuser = kind, tdata = index,
// range end, wanted count). Results leave on m_axis; tlast marks the final
// result of an item, tuser flags a result that carries a found block id.
// The block count register is written through cfg_we / cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Set, clear and get read the map byte, then update it and emit the result.
// A scan reads each map byte it visits (registered read, then the pick unit),
// reports each id it finds and ends with a closing count beat. The sequencer
// reports one id a cycle while the receiver does not stall; the single map
// read port serializes the byte visits.
// s_axis_tready is high only while no item is in progress; unknown kinds are
// taken and dropped without a result.
// Reset empties the bitmap at once (row valid flags) and sets the block
// count to 1024; no clearing pass is needed.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits before producing the next one.
module block_allocation_bitmap (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bab_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // index[9:0], range_end[20:10], want_count[26:21], zero fill
    input  logic [31:0]                s_axis_tdata,
    // kind[2:0]
    input  logic [bab_pkg::KIND_W-1:0] s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // block_id[9:0], byte_value[17:10], bit_value[18], found_count[24:19],
    // overflow[25], zero fill
    output logic [31:0]                m_axis_tdata,
    // id_valid[0]
    output logic [0:0]                 m_axis_tuser,
    output logic                       m_axis_tlast
);
    import bab_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BITOP,
        ST_LOAD,
        ST_SCAN,
        ST_CLOSE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   blocks_reg;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [ID_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   stop_reg, stop_next;
    logic [WANT_W-1:0]  want_reg, want_next;
    logic               find_reg, find_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [7:0]         work_reg, work_next;
    logic [WANT_W-1:0]  count_reg, count_next;
    logic               ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_idv_reg, out_idv_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_bit_reg, out_bit_next;
    logic [WANT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    logic [KIND_W-1:0]  in_kind;
    logic [ID_W-1:0]    in_index;
    logic [CNT_W-1:0]   in_rend;
    logic [WANT_W-1:0]  in_want;
    logic               s_fire;
    logic               out_ok;
    logic [CNT_W-1:0]   size;
    logic [CNT_W-1:0]   stop_list;
    logic [ADDR_W:0]    addr_inc;
    logic [CNT_W-1:0]   next_base;
    logic [7:0]         bit_mask;
    logic               idx_in_range;

    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [7:0]         ram_rd_data;
    logic               ram_wr_en;
    logic [7:0]         ram_wr_data;
    logic [7:0]         qual;
    pick_t              pick;

    // Unpack the input beat
    assign in_kind  = s_axis_tuser;
    assign in_index = s_axis_tdata[9:0];
    assign in_rend  = s_axis_tdata[20:10];
    assign in_want  = s_axis_tdata[26:21];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_ok        = !out_valid_reg || m_axis_tready;

    // Effective map size and list range limit
    assign size         = (blocks_reg > NUM_BLOCKS_C) ? NUM_BLOCKS_C : blocks_reg;
    assign stop_list    = (in_rend < size) ? in_rend : size;
    assign addr_inc     = {1'b0, addr_reg} + (ADDR_W + 1)'(1);
    assign next_base    = CNT_W'({addr_inc, 3'b000});
    assign bit_mask     = 8'h01 << idx_reg[2:0];
    assign idx_in_range = (CNT_W'(idx_reg) < size);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            blocks_reg <= cfg_wdata;
        end
    end

    bab_map_ram u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg[ID_W-1:3]),
        .wr_data (ram_wr_data)
    );

    bab_pick_unit u_pick (
        .addr      (addr_reg),
        .map_byte  (ram_rd_data),
        .lo        (lo_reg),
        .stop      (stop_reg),
        .want_free (find_reg),
        .work      (work_reg),
        .qual      (qual),
        .pick      (pick)
    );

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        stop_next      = stop_reg;
        want_next      = want_reg;
        find_next      = find_reg;
        addr_next      = addr_reg;
        work_next      = work_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_idv_next   = out_idv_reg;
        out_byte_next  = out_byte_reg;
        out_bit_next   = out_bit_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = addr_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = ram_rd_data;

        // Drop a beat once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    kind_next  = in_kind;
                    idx_next   = in_index;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    case (in_kind)
                        KIND_SET, KIND_CLEAR, KIND_GET:
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = in_index[ID_W-1:3];
                            state_next  = ST_BITOP;
                        end
                        KIND_LIST:
                        begin
                            lo_next     = CNT_W'(in_index);
                            stop_next   = stop_list;
                            find_next   = 1'b0;
                            addr_next   = in_index[ID_W-1:3];
                            ram_rd_addr = in_index[ID_W-1:3];
                            if (CNT_W'(in_index) >= stop_list)
                            begin
                                state_next = ST_CLOSE;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_LOAD;
                            end
                        end
                        KIND_FIND:
                        begin
                            lo_next     = '0;
                            stop_next   = size;
                            want_next   = in_want;
                            find_next   = 1'b1;
                            addr_next   = '0;
                            ram_rd_addr = '0;
                            if (in_want == '0 || size == '0)
                            begin
                                state_next = ST_CLOSE;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Update or read one flag, write back on set or clear, emit the single result
            ST_BITOP:
            begin
                if (kind_reg == KIND_SET)
                begin
                    ram_wr_data = ram_rd_data | bit_mask;
                end
                else
                begin
                    ram_wr_data = ram_rd_data & ~bit_mask;
                end
                if (out_ok)
                begin
                    ram_wr_en      = idx_in_range && (kind_reg != KIND_GET);
                    out_valid_next = 1'b1;
                    out_id_next    = '0;
                    out_idv_next   = 1'b0;
                    out_cnt_next   = '0;
                    out_ovf_next   = 1'b0;
                    out_last_next  = 1'b1;
                    out_byte_next  = '0;
                    out_bit_next   = 1'b0;
                    if (kind_reg == KIND_GET)
                    begin
                        out_bit_next = idx_in_range && ram_rd_data[idx_reg[2:0]];
                    end
                    else if (idx_in_range)
                    begin
                        out_byte_next = ram_wr_data;
                    end
                    state_next = ST_IDLE;
                end
            end

            // Take the qualified candidates of the fresh map byte
            ST_LOAD:
            begin
                work_next  = qual;
                state_next = ST_SCAN;
            end

            // Report one candidate a cycle while the output is not stalled, then advance to the next byte
            ST_SCAN:
            begin
                if (pick.found)
                begin
                    if (count_reg == MAX_REPORT)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_CLOSE;
                    end
                    else if (out_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = {addr_reg, pick.pos};
                        out_idv_next   = 1'b1;
                        out_byte_next  = '0;
                        out_bit_next   = 1'b0;
                        out_cnt_next   = '0;
                        out_ovf_next   = 1'b0;
                        out_last_next  = 1'b0;
                        count_next     = count_reg + WANT_W'(1);
                        work_next      = work_reg & ~(8'h01 << pick.pos);
                        if (find_reg && (count_reg + WANT_W'(1)) == want_reg)
                        begin
                            state_next = ST_CLOSE;
                        end
                    end
                end
                else
                begin
                    addr_next = addr_inc[ADDR_W-1:0];
                    if (next_base >= stop_reg)
                    begin
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = addr_inc[ADDR_W-1:0];
                        state_next  = ST_LOAD;
                    end
                end
            end

            // Closing count beat
            ST_CLOSE:
            begin
                if (out_ok)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = '0;
                    out_idv_next   = 1'b0;
                    out_byte_next  = '0;
                    out_bit_next   = 1'b0;
                    out_cnt_next   = count_reg;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            find_reg      <= 1'b0;
            kind_reg      <= KIND_GET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            find_reg      <= find_next;
            kind_reg      <= kind_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        lo_reg       <= lo_next;
        stop_reg     <= stop_next;
        want_reg     <= want_next;
        addr_reg     <= addr_next;
        work_reg     <= work_next;
        out_id_reg   <= out_id_next;
        out_idv_reg  <= out_idv_next;
        out_byte_reg <= out_byte_next;
        out_bit_reg  <= out_bit_next;
        out_cnt_reg  <= out_cnt_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // Pack the output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_ovf_reg, out_cnt_reg, out_bit_reg,
                            out_byte_reg, out_id_reg};
    assign m_axis_tuser  = out_idv_reg;
    assign m_axis_tlast  = out_last_reg;

    // A closing or single result never carries a block id
    a_last_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0])
        else $error("final beat flagged as carrying an id");

    // Overflow only after the report limit has been reached
    a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[24:19] == MAX_REPORT)
        else $error("overflow flagged below the report limit");

    // Find-free never reports more ids than wanted
    a_find_within_want: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE && find_reg |-> count_reg <= want_reg)
        else $error("find-free reported more ids than wanted");

    // The map is written only while a set or clear is retiring
    a_write_in_bitop: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> state_reg == ST_BITOP && out_ok && kind_reg != KIND_GET)
        else $error("map written outside a set or clear");

endmodule
